// ----- design/tepq_pkg.sv -----
// Shared constants and codes for the timed event priority queue.
package tepq_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_TAG_BITS    = 16;

	localparam int TIME_W   = 32;
	localparam int ORDER_W  = 32;
	localparam int TAG_W    = 16;
	localparam int HANDLE_W = 4;
	localparam int GEN_W    = 8;
	localparam int ACT_W    = 2;
	localparam int STAT_W   = 2;

	localparam logic [ACT_W-1:0] ACT_SCHED  = 2'd0;
	localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd1;
	localparam logic [ACT_W-1:0] ACT_POP    = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
	localparam logic [STAT_W-1:0] STAT_NOEFFECT = 2'd3;

endpackage

// ----- design/tepq_entry_mem.sv -----
// Entry store: time, sequence and tag per slot, one write and one registered read port.
module tepq_entry_mem #(
	parameter int DEPTH = tepq_pkg::DEF_QUEUE_DEPTH,
	parameter int WIDTH = 80
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- design/tepq_gen_mem.sv -----
// Slot generation store; slots never written read as zero.
module tepq_gen_mem #(
	parameter int DEPTH = tepq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       wr_en,
	input  logic [$clog2(DEPTH)-1:0]   wr_addr,
	input  logic [tepq_pkg::GEN_W-1:0] wr_data,
	input  logic [$clog2(DEPTH)-1:0]   rd_addr,
	output logic [tepq_pkg::GEN_W-1:0] rd_data
);

	logic [tepq_pkg::GEN_W-1:0] mem [DEPTH];
	logic [tepq_pkg::GEN_W-1:0] rd_raw_q;
	logic [DEPTH-1:0]           written_q;
	logic                       rd_written_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_raw_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q    <= '0;
			rd_written_q <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q[wr_addr] <= 1'b1;
			end
			rd_written_q <= written_q[rd_addr];
		end
	end

	assign rd_data = rd_written_q ? rd_raw_q : '0;

endmodule

// ----- design/timed_event_priority_queue_core.sv -----
// Timed event priority queue: schedule, cancel by handle and generation, pop earliest.
//
// Schedule and cancel read the slot's generation from its memory, then register
// the result. A pop sweeps the entry memory one slot per cycle through its single
// read port to find the least time, oldest sequence first on ties, and then reads
// and steps the winner's generation; an empty queue skips that step. One word is
// in work at a time; a new word is taken while the previous result still waits
// in the output register. Live flags sit in flip-flops cleared by reset, so no
// clearing pass follows reset.
module timed_event_priority_queue_core #(
	parameter int QUEUE_DEPTH = tepq_pkg::DEF_QUEUE_DEPTH,
	parameter int TAG_BITS    = tepq_pkg::DEF_TAG_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // event_time, event_tag, cancel_handle, cancel_generation
	input  logic [1:0]  s_tuser,  // action
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [95:0] m_tdata,  // handle, generation, fired_time, fired_tag, current_time
	output logic [1:0]  m_tuser   // status
);

	localparam int SLOT_W = $clog2(QUEUE_DEPTH);
	localparam int TW     = (TAG_BITS < tepq_pkg::TAG_W) ? TAG_BITS : tepq_pkg::TAG_W;
	localparam int CW     = (SLOT_W > tepq_pkg::HANDLE_W) ? SLOT_W : tepq_pkg::HANDLE_W;
	localparam int ENT_W  = tepq_pkg::ORDER_W + tepq_pkg::TIME_W + TW;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCHED  = 3'd1;
	localparam logic [2:0] S_CANCEL = 3'd2;
	localparam logic [2:0] S_SCAN   = 3'd3;
	localparam logic [2:0] S_POPGEN = 3'd4;
	localparam logic [2:0] S_POPFIN = 3'd5;
	localparam logic [2:0] S_RESP   = 3'd6;

	logic [2:0]                    state_q;
	logic [QUEUE_DEPTH-1:0]        live_q;
	logic [tepq_pkg::ORDER_W-1:0]  next_order_q;
	logic [tepq_pkg::TIME_W-1:0]   now_q;
	logic [SLOT_W-1:0]             slot_q;
	logic [SLOT_W-1:0]             scan_q;
	logic                          best_found_q;
	logic [tepq_pkg::TIME_W-1:0]   best_time_q;
	logic [tepq_pkg::ORDER_W-1:0]  best_age_q;
	logic [TW-1:0]                 best_tag_q;
	logic [tepq_pkg::TIME_W-1:0]   in_time_q;
	logic [TW-1:0]                 in_tag_q;
	logic [tepq_pkg::GEN_W-1:0]    in_gen_q;
	logic [tepq_pkg::STAT_W-1:0]   resp_stat_q;

	logic                          m_valid_q;
	logic [tepq_pkg::STAT_W-1:0]   o_stat_q;
	logic [tepq_pkg::HANDLE_W-1:0] o_handle_q;
	logic [tepq_pkg::GEN_W-1:0]    o_gen_q;
	logic [tepq_pkg::TIME_W-1:0]   o_ftime_q;
	logic [tepq_pkg::TAG_W-1:0]    o_ftag_q;

	logic [tepq_pkg::ACT_W-1:0]    in_act;
	logic [tepq_pkg::TIME_W-1:0]   in_time;
	logic [tepq_pkg::TAG_W-1:0]    in_tag;
	logic [tepq_pkg::HANDLE_W-1:0] in_handle;
	logic [tepq_pkg::GEN_W-1:0]    in_gen;
	logic                          accept;
	logic                          can_emit;
	logic                          emit;
	logic [CW-1:0]                 ch_ext;
	logic [SLOT_W-1:0]             ch_idx;
	logic                          ch_in_range;
	logic [SLOT_W-1:0]             free_slot;
	logic                          all_live;
	logic [CW-1:0]                 slot_ext;

	logic                          ent_wr_en;
	logic [ENT_W-1:0]              ent_wr_data;
	logic [SLOT_W-1:0]             ent_rd_addr;
	logic [ENT_W-1:0]              ent_rd_data;
	logic [tepq_pkg::TIME_W-1:0]   cand_time;
	logic [tepq_pkg::ORDER_W-1:0]  cand_order;
	logic [TW-1:0]                 cand_tag;
	logic [tepq_pkg::ORDER_W-1:0]  cand_age;
	logic                          cand_better;

	logic                          gen_wr_en;
	logic [SLOT_W-1:0]             gen_rd_addr;
	logic [tepq_pkg::GEN_W-1:0]    gen_val;
	logic                          gen_match;

	assign in_time   = s_tdata[31:0];
	assign in_tag    = s_tdata[47:32];
	assign in_handle = s_tdata[51:48];
	assign in_gen    = s_tdata[59:52];
	assign in_act    = s_tuser;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign can_emit = !m_valid_q || m_tready;
	assign emit     = can_emit && (state_q inside {S_SCHED, S_CANCEL, S_POPFIN, S_RESP});

	assign ch_ext      = CW'(in_handle);
	assign ch_idx      = ch_ext[SLOT_W-1:0];
	assign ch_in_range = (32'(in_handle) < QUEUE_DEPTH);
	assign slot_ext    = CW'(slot_q);

	always_comb begin
		free_slot = '0;
		for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
			if (!live_q[i]) begin
				free_slot = SLOT_W'(i);
			end
		end
	end
	assign all_live = &live_q;

	// entry word: {order, time, tag}
	assign ent_wr_en   = (state_q == S_SCHED) && can_emit;
	assign ent_wr_data = {next_order_q, in_time_q, in_tag_q};
	assign ent_rd_addr = (state_q == S_SCAN) ? scan_q + SLOT_W'(1) : '0;

	tepq_entry_mem #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (ENT_W)
	) u_entry_mem (
		.clk     (clk),
		.wr_en   (ent_wr_en),
		.wr_addr (slot_q),
		.wr_data (ent_wr_data),
		.rd_addr (ent_rd_addr),
		.rd_data (ent_rd_data)
	);

	assign cand_tag    = ent_rd_data[TW-1:0];
	assign cand_time   = ent_rd_data[TW +: tepq_pkg::TIME_W];
	assign cand_order  = ent_rd_data[TW + tepq_pkg::TIME_W +: tepq_pkg::ORDER_W];
	assign cand_age    = next_order_q - cand_order;
	assign cand_better = live_q[scan_q] && (!best_found_q || (cand_time < best_time_q) ||
		((cand_time == best_time_q) && (cand_age > best_age_q)));

	assign gen_rd_addr = (state_q == S_IDLE) ?
		((in_act == tepq_pkg::ACT_SCHED) ? free_slot : ch_idx) : slot_q;
	assign gen_match   = (gen_val == in_gen_q);
	assign gen_wr_en   = can_emit &&
		(((state_q == S_CANCEL) && gen_match) || (state_q == S_POPFIN));

	tepq_gen_mem #(
		.DEPTH (QUEUE_DEPTH)
	) u_gen_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (gen_wr_en),
		.wr_addr (slot_q),
		.wr_data (gen_val + tepq_pkg::GEN_W'(1)),
		.rd_addr (gen_rd_addr),
		.rd_data (gen_val)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			in_time_q <= in_time;
			in_tag_q  <= in_tag[TW-1:0];
			in_gen_q  <= in_gen;
		end
		if (state_q == S_SCAN && cand_better) begin
			best_time_q <= cand_time;
			best_age_q  <= cand_age;
			best_tag_q  <= cand_tag;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			live_q       <= '0;
			next_order_q <= '0;
			now_q        <= '0;
			slot_q       <= '0;
			scan_q       <= '0;
			best_found_q <= 1'b0;
			resp_stat_q  <= tepq_pkg::STAT_OK;
			m_valid_q    <= 1'b0;
			o_stat_q     <= tepq_pkg::STAT_OK;
			o_handle_q   <= '0;
			o_gen_q      <= '0;
			o_ftime_q    <= '0;
			o_ftag_q     <= '0;
		end else begin
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_act)
							tepq_pkg::ACT_SCHED: begin
								if (all_live) begin
									resp_stat_q <= tepq_pkg::STAT_FULL;
									state_q     <= S_RESP;
								end else begin
									slot_q  <= free_slot;
									state_q <= S_SCHED;
								end
							end
							tepq_pkg::ACT_CANCEL: begin
								if (ch_in_range && live_q[ch_idx]) begin
									slot_q  <= ch_idx;
									state_q <= S_CANCEL;
								end else begin
									resp_stat_q <= tepq_pkg::STAT_NOEFFECT;
									state_q     <= S_RESP;
								end
							end
							tepq_pkg::ACT_POP: begin
								scan_q       <= '0;
								best_found_q <= 1'b0;
								state_q      <= S_SCAN;
							end
							default: begin
								resp_stat_q <= tepq_pkg::STAT_OK;
								state_q     <= S_RESP;
							end
						endcase
					end
				end
				S_SCHED: begin
					if (can_emit) begin
						live_q[slot_q] <= 1'b1;
						next_order_q   <= next_order_q + tepq_pkg::ORDER_W'(1);
						o_stat_q       <= tepq_pkg::STAT_OK;
						o_handle_q     <= slot_ext[tepq_pkg::HANDLE_W-1:0];
						o_gen_q        <= gen_val;
						o_ftime_q      <= '0;
						o_ftag_q       <= '0;
						state_q        <= S_IDLE;
					end
				end
				S_CANCEL: begin
					if (can_emit) begin
						if (gen_match) begin
							live_q[slot_q] <= 1'b0;
							o_stat_q       <= tepq_pkg::STAT_OK;
						end else begin
							o_stat_q <= tepq_pkg::STAT_NOEFFECT;
						end
						o_handle_q <= '0;
						o_gen_q    <= '0;
						o_ftime_q  <= '0;
						o_ftag_q   <= '0;
						state_q    <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (cand_better) begin
						best_found_q <= 1'b1;
						slot_q       <= scan_q;
					end
					scan_q <= scan_q + SLOT_W'(1);
					if (32'(scan_q) == QUEUE_DEPTH - 1) begin
						if (best_found_q || cand_better) begin
							state_q <= S_POPGEN;
						end else begin
							resp_stat_q <= tepq_pkg::STAT_EMPTY;
							state_q     <= S_RESP;
						end
					end
				end
				S_POPGEN: begin
					state_q <= S_POPFIN;
				end
				S_POPFIN: begin
					if (can_emit) begin
						live_q[slot_q] <= 1'b0;
						now_q          <= best_time_q;
						o_stat_q       <= tepq_pkg::STAT_OK;
						o_handle_q     <= '0;
						o_gen_q        <= '0;
						o_ftime_q      <= best_time_q;
						o_ftag_q       <= tepq_pkg::TAG_W'(best_tag_q);
						state_q        <= S_IDLE;
					end
				end
				S_RESP: begin
					if (can_emit) begin
						o_stat_q   <= resp_stat_q;
						o_handle_q <= '0;
						o_gen_q    <= '0;
						o_ftime_q  <= '0;
						o_ftag_q   <= '0;
						state_q    <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = o_stat_q;
	assign m_tdata  = {4'b0, now_q, o_ftag_q, o_ftime_q, o_gen_q, o_handle_q};

	a_pop_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && in_act == tepq_pkg::ACT_POP) |=> (state_q == S_SCAN))
		else $error("pop did not start the entry sweep");

	a_sched_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCHED) |-> !live_q[slot_q])
		else $error("schedule targets a live slot");

	a_cancel_slot_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CANCEL) |-> live_q[slot_q])
		else $error("cancel targets a free slot");

	a_popfin_has_winner: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POPFIN) |-> (best_found_q && live_q[slot_q]))
		else $error("pop retires without a live winner");

endmodule
